### hw/rtl/skht_pkg.sv
// skht_pkg: command and status codes and fixed port widths for the sorted key/handle table
// no dependencies

package skht_pkg;

   localparam int KEY_W      = 32;
   localparam int HANDLE_W   = 32;
   localparam int POSITION_W = 10;
   localparam int COUNT_W    = 11;

   typedef logic [1:0] command_type;
   typedef logic [1:0] status_type;

   localparam command_type CMD_ADD    = 2'd0;
   localparam command_type CMD_REMOVE = 2'd1;
   localparam command_type CMD_LOOKUP = 2'd2;

   localparam status_type ST_OK        = 2'd0;
   localparam status_type ST_NOT_FOUND = 2'd1;
   localparam status_type ST_FULL      = 2'd2;
   localparam status_type ST_ORDER     = 2'd3;

endpackage

### hw/rtl/skht_ram.sv
// skht_ram: generic single-port-write, single-port-read synchronous ram
// registered read data; no dependencies

module skht_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/sorted_key_handle_table.sv
// sorted_key_handle_table: ascending key table with handles, binary search lookup and remove
// uses skht_pkg and two skht_ram instances (keys, handles)
//
// A request is taken when start is high and busy is low; exactly one result follows, shown on
// the rsp_ ports for a single cycle while rsp_strobe is high, and the receiver cannot stall it.
// Add to an empty or full table reads no memory, else it reads the last key once. Lookup and
// remove make binary search probes of the key memory, at most ceil(log2(entry_count+1)) probes.
// Remove then moves each later entry down one place through the memory read and write ports,
// one entry per cycle. The result strobe comes in the cycle after the last of these steps
// (accept, read, probe or move); busy drops with it, so the next request may start then.

module sorted_key_handle_table
   import skht_pkg::*;
#(
   parameter int TABLE_DEPTH = 1024
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [1:0]            req_command,
   input  logic [KEY_W-1:0]      req_entity_key,
   input  logic [HANDLE_W-1:0]   req_handle_in,
   output logic                  rsp_strobe,
   output logic [1:0]            rsp_status,
   output logic [POSITION_W-1:0] rsp_position,
   output logic [HANDLE_W-1:0]   rsp_handle_out,
   output logic [COUNT_W-1:0]    rsp_entry_count
);

   localparam int IDX_W = $clog2(TABLE_DEPTH);
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

   localparam logic [1:0] S_IDLE    = 2'd0;
   localparam logic [1:0] S_ADD_CHK = 2'd1;
   localparam logic [1:0] S_SRCH    = 2'd2;
   localparam logic [1:0] S_SHIFT   = 2'd3;

   logic [1:0]          state_ff, state_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic                strobe_ff, strobe_in;

   command_type         cmd_ff, cmd_in;
   logic [KEY_W-1:0]    key_ff, key_in;
   logic [HANDLE_W-1:0] hin_ff, hin_in;
   logic [CNT_W-1:0]    lo_ff, lo_in;
   logic [CNT_W-1:0]    hi_ff, hi_in;
   logic [CNT_W-1:0]    mid_ff, mid_in;
   logic [CNT_W-1:0]    ptr_ff, ptr_in;
   status_type          status_ff, status_in;
   logic [IDX_W-1:0]    pos_ff, pos_in;
   logic [HANDLE_W-1:0] hout_ff, hout_in;

   logic                wr_en;
   logic [IDX_W-1:0]    wr_addr;
   logic [KEY_W-1:0]    wr_key;
   logic [HANDLE_W-1:0] wr_handle;
   logic [IDX_W-1:0]    rd_addr;
   logic [KEY_W-1:0]    key_rdata;
   logic [HANDLE_W-1:0] handle_rdata;

   logic                accept;
   logic                key_eq, key_lt;
   logic [CNT_W-1:0]    lo_next, hi_next, mid_next;
   logic [CNT_W-1:0]    mid_plus1, ptr_plus1, ptr_plus2, count_minus1;
   logic [31:0]         pos_wide, count_wide;

   assign busy   = (state_ff != S_IDLE);
   assign accept = start && !busy;

   assign key_eq       = (key_rdata == key_ff);
   assign key_lt       = (key_rdata < key_ff);
   assign mid_plus1    = mid_ff + CNT_W'(1);
   assign ptr_plus1    = ptr_ff + CNT_W'(1);
   assign ptr_plus2    = ptr_ff + CNT_W'(2);
   assign count_minus1 = count_ff - CNT_W'(1);
   assign lo_next      = key_lt ? mid_plus1 : lo_ff;
   assign hi_next      = key_lt ? hi_ff : mid_ff;
   assign mid_next     = lo_next + ((hi_next - lo_next) >> 1);

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      strobe_in = 1'b0;
      cmd_in    = cmd_ff;
      key_in    = key_ff;
      hin_in    = hin_ff;
      lo_in     = lo_ff;
      hi_in     = hi_ff;
      mid_in    = mid_ff;
      ptr_in    = ptr_ff;
      status_in = status_ff;
      pos_in    = pos_ff;
      hout_in   = hout_ff;
      wr_en     = 1'b0;
      wr_addr   = count_ff[IDX_W-1:0];
      wr_key    = key_ff;
      wr_handle = hin_ff;
      rd_addr   = mid_next[IDX_W-1:0];

      unique case (state_ff)
         S_IDLE: begin
            rd_addr = (req_command == CMD_ADD) ? count_minus1[IDX_W-1:0]
                                               : IDX_W'(count_ff >> 1);
            if (accept) begin
               cmd_in    = req_command;
               key_in    = req_entity_key;
               hin_in    = req_handle_in;
               status_in = ST_OK;
               pos_in    = '0;
               hout_in   = '0;
               lo_in     = '0;
               hi_in     = count_ff;
               mid_in    = count_ff >> 1;
               case (req_command)
                  CMD_ADD: begin
                     if (count_ff >= CNT_W'(TABLE_DEPTH)) begin
                        status_in = ST_FULL;
                        strobe_in = 1'b1;
                     end else if (count_ff == '0) begin
                        wr_en     = 1'b1;
                        wr_addr   = '0;
                        wr_key    = req_entity_key;
                        wr_handle = req_handle_in;
                        count_in  = CNT_W'(1);
                        strobe_in = 1'b1;
                     end else begin
                        state_in = S_ADD_CHK;
                     end
                  end
                  CMD_REMOVE, CMD_LOOKUP: begin
                     if (count_ff == '0) begin
                        status_in = ST_NOT_FOUND;
                        strobe_in = 1'b1;
                     end else begin
                        state_in = S_SRCH;
                     end
                  end
                  default: begin
                     strobe_in = 1'b1;
                  end
               endcase
            end
         end
         S_ADD_CHK: begin
            state_in  = S_IDLE;
            strobe_in = 1'b1;
            if (key_ff > key_rdata) begin
               wr_en    = 1'b1;
               pos_in   = count_ff[IDX_W-1:0];
               count_in = count_ff + CNT_W'(1);
            end else begin
               status_in = ST_ORDER;
            end
         end
         S_SRCH: begin
            if (key_eq) begin
               rd_addr = mid_plus1[IDX_W-1:0];
               pos_in  = mid_ff[IDX_W-1:0];
               ptr_in  = mid_ff;
               if (cmd_ff == CMD_LOOKUP) begin
                  hout_in   = handle_rdata;
                  state_in  = S_IDLE;
                  strobe_in = 1'b1;
               end else if (mid_plus1 == count_ff) begin
                  count_in  = count_minus1;
                  state_in  = S_IDLE;
                  strobe_in = 1'b1;
               end else begin
                  state_in = S_SHIFT;
               end
            end else if (lo_next < hi_next) begin
               lo_in  = lo_next;
               hi_in  = hi_next;
               mid_in = mid_next;
            end else begin
               status_in = ST_NOT_FOUND;
               state_in  = S_IDLE;
               strobe_in = 1'b1;
            end
         end
         S_SHIFT: begin
            wr_en     = 1'b1;
            wr_addr   = ptr_ff[IDX_W-1:0];
            wr_key    = key_rdata;
            wr_handle = handle_rdata;
            rd_addr   = ptr_plus2[IDX_W-1:0];
            ptr_in    = ptr_plus1;
            if (ptr_plus2 == count_ff) begin
               count_in  = count_minus1;
               state_in  = S_IDLE;
               strobe_in = 1'b1;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         count_ff  <= '0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff    <= cmd_in;
      key_ff    <= key_in;
      hin_ff    <= hin_in;
      lo_ff     <= lo_in;
      hi_ff     <= hi_in;
      mid_ff    <= mid_in;
      ptr_ff    <= ptr_in;
      status_ff <= status_in;
      pos_ff    <= pos_in;
      hout_ff   <= hout_in;
   end

   skht_ram #(
      .WIDTH(KEY_W),
      .DEPTH(TABLE_DEPTH)
   ) u_key_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_key),
      .rd_addr(rd_addr),
      .rd_data(key_rdata)
   );

   skht_ram #(
      .WIDTH(HANDLE_W),
      .DEPTH(TABLE_DEPTH)
   ) u_handle_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_handle),
      .rd_addr(rd_addr),
      .rd_data(handle_rdata)
   );

   assign pos_wide   = 32'(pos_ff);
   assign count_wide = 32'(count_ff);

   assign rsp_strobe      = strobe_ff;
   assign rsp_status      = status_ff;
   assign rsp_position    = pos_wide[POSITION_W-1:0];
   assign rsp_handle_out  = hout_ff;
   assign rsp_entry_count = count_wide[COUNT_W-1:0];

endmodule

### test/sorted_key_handle_table_tb.sv
// sorted_key_handle_table_tb: checks each response of the sorted key/handle table against a
// behavioral table model, with directed and constrained-by-hand random request streams
// depends on skht_pkg and sorted_key_handle_table

module sorted_key_handle_table_tb
   import skht_pkg::*;
();

   localparam int DEPTH       = 1024;
   localparam int PHASE_ITEMS = 30;
   localparam int STALL_LIMIT = 8000;
   localparam int TAIL_CYCLES = 16;
   localparam command_type CMD_UNUSED = 2'd3;

   typedef struct {
      command_type         command;
      logic [KEY_W-1:0]    key;
      logic [HANDLE_W-1:0] handle;
   } table_request_type;

   typedef struct {
      table_request_type     cause;
      status_type            status;
      logic [POSITION_W-1:0] position;
      logic [HANDLE_W-1:0]   handle;
      logic [COUNT_W-1:0]    count;
   } table_response_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  start = 1'b0;
   logic                  busy;
   logic [1:0]            req_command = '0;
   logic [KEY_W-1:0]      req_entity_key = '0;
   logic [HANDLE_W-1:0]   req_handle_in = '0;
   logic                  rsp_strobe;
   logic [1:0]            rsp_status;
   logic [POSITION_W-1:0] rsp_position;
   logic [HANDLE_W-1:0]   rsp_handle_out;
   logic [COUNT_W-1:0]    rsp_entry_count;

   table_request_type  request_backlog[$];
   table_response_type expected_responses[$];
   logic [KEY_W-1:0] planned_keys[$];

   logic [KEY_W-1:0]    model_keys[DEPTH];
   logic [HANDLE_W-1:0] model_handles[DEPTH];
   int                  model_fill = 0;

   int idle_pct = 0;
   int mismatch_count = 0;
   int stall_cycles = 0;

   sorted_key_handle_table #(
      .TABLE_DEPTH(DEPTH)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_command(req_command),
      .req_entity_key(req_entity_key),
      .req_handle_in(req_handle_in),
      .rsp_strobe(rsp_strobe),
      .rsp_status(rsp_status),
      .rsp_position(rsp_position),
      .rsp_handle_out(rsp_handle_out),
      .rsp_entry_count(rsp_entry_count)
   );

   always #2 clock = ~clock;

   function automatic int model_find(logic [KEY_W-1:0] key);
      int lo;
      int hi;
      int mid;
      lo = 0;
      hi = model_fill;
      while (lo < hi) begin
         mid = lo + (hi - lo) / 2;
         if (model_keys[mid] == key)
            return mid;
         if (model_keys[mid] < key)
            lo = mid + 1;
         else
            hi = mid;
      end
      return -1;
   endfunction

   function automatic table_response_type table_apply(table_request_type rq);
      table_response_type rs;
      int idx;
      rs.cause = rq;
      rs.status = ST_OK;
      rs.position = '0;
      rs.handle = '0;
      idx = -1;
      case (rq.command)
         CMD_ADD: begin
            if (model_fill >= DEPTH) begin
               rs.status = ST_FULL;
            end else if (model_fill > 0 && rq.key <= model_keys[model_fill-1]) begin
               rs.status = ST_ORDER;
            end else begin
               model_keys[model_fill] = rq.key;
               model_handles[model_fill] = rq.handle;
               rs.position = model_fill[POSITION_W-1:0];
               model_fill++;
            end
         end
         CMD_REMOVE: begin
            idx = model_find(rq.key);
            if (idx < 0) begin
               rs.status = ST_NOT_FOUND;
            end else begin
               for (int i = idx; i < model_fill - 1; i++) begin
                  model_keys[i] = model_keys[i+1];
                  model_handles[i] = model_handles[i+1];
               end
               model_fill--;
               rs.position = idx[POSITION_W-1:0];
            end
         end
         CMD_LOOKUP: begin
            idx = model_find(rq.key);
            if (idx < 0) begin
               rs.status = ST_NOT_FOUND;
            end else begin
               rs.position = idx[POSITION_W-1:0];
               rs.handle = model_handles[idx];
            end
         end
         default: begin
         end
      endcase
      rs.count = model_fill[COUNT_W-1:0];
      return rs;
   endfunction

   function automatic int planned_index(logic [KEY_W-1:0] key);
      foreach (planned_keys[i])
         if (planned_keys[i] == key)
            return i;
      return -1;
   endfunction

   task automatic plan_request(command_type cmd, logic [KEY_W-1:0] key,
                               logic [HANDLE_W-1:0] handle);
      table_request_type rq;
      int idx;
      rq.command = cmd;
      rq.key = key;
      rq.handle = handle;
      request_backlog = {request_backlog, rq};
      if (cmd == CMD_ADD) begin
         if (planned_keys.size() < DEPTH &&
             (planned_keys.size() == 0 || key > planned_keys[$]))
            planned_keys = {planned_keys, key};
      end else if (cmd == CMD_REMOVE) begin
         idx = planned_index(key);
         if (idx >= 0)
            planned_keys.delete(idx);
      end
   endtask

   task automatic plan_random_request();
      int unsigned pick;
      int unsigned sub;
      int n;
      logic [KEY_W:0] sum;
      logic [KEY_W-1:0] key;
      logic [KEY_W-1:0] present;
      command_type cmd;
      n = planned_keys.size();
      pick = $urandom_range(99);
      sub = $urandom_range(99);
      key = $urandom();
      present = (n > 0) ? planned_keys[$urandom_range(n - 1)] : $urandom();
      if (pick < 45) begin
         cmd = CMD_ADD;
         if (sub < 75) begin
            if (n == 0) begin
               key = $urandom_range(32'h4000_0000);
            end else begin
               sum = {1'b0, planned_keys[$]} + $urandom_range(32'h0010_0000, 1);
               key = sum[KEY_W] ? '1 : sum[KEY_W-1:0];
            end
         end else if (sub < 85) begin
            key = (n > 0) ? planned_keys[$] : '0;
         end
      end else if (pick < 95) begin
         cmd = (pick < 70) ? CMD_LOOKUP : CMD_REMOVE;
         if (n > 0 && cmd == CMD_REMOVE && sub < 25)
            key = planned_keys[$];
         else if (sub < 75)
            key = present;
         else if (sub < 88)
            key = present + ($urandom_range(1) ? 32'd1 : 32'hFFFF_FFFF);
      end else begin
         cmd = CMD_UNUSED;
      end
      plan_request(cmd, key, $urandom());
   endtask

   task automatic plan_fill();
      longint unsigned headroom;
      longint unsigned stride;
      logic [KEY_W-1:0] key;
      while (planned_keys.size() > 0 &&
             (64'hFFFF_FFFF - planned_keys[$]) < longint'(DEPTH - planned_keys.size() + 1))
         plan_request(CMD_REMOVE, planned_keys[$], $urandom());
      if (planned_keys.size() == 0)
         plan_request(CMD_ADD, $urandom_range(1000), $urandom());
      headroom = 64'hFFFF_FFFF - planned_keys[$];
      stride = headroom / longint'(DEPTH - planned_keys.size() + 1);
      while (planned_keys.size() < DEPTH) begin
         key = planned_keys[$] + $urandom_range(stride[31:0], 1);
         plan_request(CMD_ADD, key, $urandom());
      end
      plan_request(CMD_ADD, planned_keys[$] + 32'd1, $urandom());
      plan_request(CMD_ADD, $urandom(), $urandom());
      plan_request(CMD_LOOKUP, planned_keys[0], $urandom());
      plan_request(CMD_LOOKUP, planned_keys[$], $urandom());
      plan_request(CMD_LOOKUP, planned_keys[DEPTH/2], $urandom());
   endtask

   task automatic wait_backlog_drained();
      while (request_backlog.size() != 0 || start)
         @(posedge clock);
   endtask

   // request driver
   always @(posedge clock) begin
      table_request_type rq;
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            rq.command = req_command;
            rq.key = req_entity_key;
            rq.handle = req_handle_in;
            expected_responses = {expected_responses, table_apply(rq)};
         end
         if (!start || !busy) begin
            if (request_backlog.size() != 0 && $urandom_range(99) >= idle_pct) begin
               rq = request_backlog.pop_front();
               start <= 1'b1;
               req_command <= rq.command;
               req_entity_key <= rq.key;
               req_handle_in <= rq.handle;
            end else begin
               start <= 1'b0;
               req_command <= 2'($urandom_range(3));
               req_entity_key <= $urandom();
               req_handle_in <= $urandom();
            end
         end
      end
   end

   // response monitor
   always @(posedge clock) begin
      table_response_type ex;
      if (!reset && rsp_strobe) begin
         if (expected_responses.size() == 0) begin
            if (mismatch_count < 10)
               $display("response with nothing expected: status %0d pos %0d handle %h count %0d",
                        rsp_status, rsp_position, rsp_handle_out, rsp_entry_count);
            mismatch_count++;
         end else begin
            ex = expected_responses.pop_front();
            if (rsp_status !== ex.status || rsp_position !== ex.position ||
                rsp_handle_out !== ex.handle || rsp_entry_count !== ex.count) begin
               if (mismatch_count < 10) begin
                  $display("mismatch for cmd %0d key %h handle %h",
                           ex.cause.command, ex.cause.key, ex.cause.handle);
                  $display("  expected status %0d pos %0d handle %h count %0d",
                           ex.status, ex.position, ex.handle, ex.count);
                  $display("  actual   status %0d pos %0d handle %h count %0d",
                           rsp_status, rsp_position, rsp_handle_out, rsp_entry_count);
               end
               mismatch_count++;
            end
         end
      end
   end

   // watchdog on cycles without any handshake
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("sorted_key_handle_table test failed");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      // directed: empty table, key range ends, order errors, shifts on remove
      plan_request(CMD_LOOKUP, 32'd5, 32'd0);
      plan_request(CMD_REMOVE, 32'd5, 32'd0);
      plan_request(CMD_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      plan_request(CMD_ADD, 32'd0, 32'hFFFF_FFFF);
      plan_request(CMD_ADD, 32'd0, 32'h1234_5678);
      plan_request(CMD_ADD, 32'd100, 32'd0);
      plan_request(CMD_ADD, 32'd50, 32'h0BAD_F00D);
      plan_request(CMD_ADD, 32'hFFFF_FFFF, 32'hA5A5_A5A5);
      plan_request(CMD_ADD, 32'hFFFF_FFFF, 32'h5A5A_5A5A);
      plan_request(CMD_LOOKUP, 32'd0, 32'd0);
      plan_request(CMD_LOOKUP, 32'hFFFF_FFFF, 32'd0);
      plan_request(CMD_LOOKUP, 32'd100, 32'hFFFF_FFFF);
      plan_request(CMD_LOOKUP, 32'd99, 32'd0);
      plan_request(CMD_UNUSED, 32'd100, 32'd7);
      plan_request(CMD_REMOVE, 32'd0, 32'd0);
      plan_request(CMD_LOOKUP, 32'd100, 32'd0);
      plan_request(CMD_REMOVE, 32'hFFFF_FFFF, 32'd0);
      plan_request(CMD_ADD, 32'h8000_0000, 32'h5A5A_5A5A);
      plan_request(CMD_REMOVE, 32'd100, 32'd0);
      plan_request(CMD_REMOVE, 32'd100, 32'd0);
      plan_request(CMD_REMOVE, 32'h8000_0000, 32'd0);
      plan_request(CMD_ADD, 32'h7FFF_FFFF, 32'h8000_0001);
      plan_request(CMD_LOOKUP, 32'h7FFF_FFFF, 32'd0);
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      wait_backlog_drained();

      idle_pct = 34;
      repeat (PHASE_ITEMS) plan_random_request();
      wait_backlog_drained();

      idle_pct = 75;
      repeat (PHASE_ITEMS) plan_random_request();
      wait_backlog_drained();

      // no gaps: fill to capacity, then work on a full table
      idle_pct = 0;
      plan_fill();
      repeat (PHASE_ITEMS) plan_random_request();
      wait_backlog_drained();

      while (expected_responses.size() != 0)
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && expected_responses.size() == 0)
         $display("sorted_key_handle_table test passed");
      else
         $display("sorted_key_handle_table test failed");
      $finish;
   end

endmodule
